FILE: hw/rtl/nfa_pkg.sv
// Shared types and constants for the NFA string acceptor.
// Used by nfa_scan and nfa_string_acceptor; depends on nothing else.
package nfa_pkg;

    localparam int NUM_STATES_DEF      = 32;
    localparam int MAX_TRANSITIONS_DEF = 64;

    localparam int ACTION_W   = 2;
    localparam int STATE_ID_W = 5;
    localparam int SYMBOL_W   = 8;
    localparam int NUM_INIT_W = 6;
    localparam int MASK_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_SYMBOL = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_INITIAL = 1'b0,
        CFG_ACCEPT_MASK = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // One stored transition, 18 bits.
    typedef struct packed {
        logic [STATE_ID_W-1:0] from_state;
        logic [STATE_ID_W-1:0] to_state;
        logic [SYMBOL_W-1:0]   symbol;
    } t_trans;

    typedef struct packed {
        logic   en;
        t_trans entry;
    } t_wr;

    typedef struct packed {
        logic                start;
        logic [SYMBOL_W-1:0] symbol;
    } t_scan_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_sts;

endpackage

FILE: hw/rtl/nfa_string_acceptor.sv
// Top level of the NFA string acceptor: stream ports, config registers,
// active-state set and result register. Depends on nfa_pkg and nfa_scan.
//
// Simulates a nondeterministic automaton without empty moves over a stream
// of command transactions. Each input transaction adds a (from, symbol, to)
// transition, clears the transition table, feeds one string symbol, or ends
// the string; only end of string produces an output transaction, carrying
// the accept decision and the sticky table-overflow flag. A string symbol
// walks the stored transition list once through the single read port of
// the transition memory, one entry per cycle; no input is taken during that
// walk. An end of string waits only while the previous result still sits
// unread in the output register; other commands pass it. Transitions past
// MAX_TRANSITIONS are dropped and set the overflow flag until the next
// clear. Write num_initial and accept_mask only while the block is idle.
module nfa_string_acceptor #(
    parameter int NUM_STATES      = nfa_pkg::NUM_STATES_DEF,
    parameter int MAX_TRANSITIONS = nfa_pkg::MAX_TRANSITIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Config write port
    input  logic                           i_cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] action, [6:2] from_state, [11:7] to_state, [19:12] symbol, rest zero
    input  logic [nfa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] accepted, [1] table_overflow, rest zero
    output logic [nfa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import nfa_pkg::*;

    localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CW = $clog2(MAX_TRANSITIONS + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [NUM_STATES-1:0] r_active;
    logic                  r_in_string;
    logic                  r_ovf;
    logic [NUM_INIT_W-1:0] r_num_init;
    logic [MASK_W-1:0]     r_acc_mask;
    logic                  r_out_valid;
    logic                  r_out_acc;
    logic                  r_out_ovf;

    t_action               in_action;
    t_trans                in_trans;
    logic                  in_acc;
    t_wr                   wr;
    t_scan_cmd             scan_cmd;
    t_scan_sts             scan_sts;
    logic [NUM_STATES-1:0] scan_next;
    logic [NUM_STATES-1:0] init_set;
    logic [NUM_STATES-1:0] start_set;
    logic [NUM_STATES-1:0] mask_set;
    logic [63:0]           mask_ext;
    logic                  out_pop;

    // Unpack the command transaction.
    assign in_action           = t_action'(s_axis_tdata[1:0]);
    assign in_trans.from_state = s_axis_tdata[6:2];
    assign in_trans.to_state   = s_axis_tdata[11:7];
    assign in_trans.symbol     = s_axis_tdata[19:12];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_pop = r_out_valid && m_axis_tready;

    // Initial set saturates at NUM_STATES; states above 31 never accept.
    always_comb begin
        for (int s = 0; s < NUM_STATES; s++) begin
            init_set[s] = (7'(s) < {1'b0, r_num_init});
        end
        mask_ext  = {32'b0, r_acc_mask};
        mask_set  = mask_ext[NUM_STATES-1:0];
        start_set = r_in_string ? r_active : init_set;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_action == ACT_SYMBOL) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and command outputs of the FSM.
    always_comb begin
        s_axis_tready   = 1'b0;
        scan_cmd.start  = 1'b0;
        scan_cmd.symbol = in_trans.symbol;
        wr.en           = 1'b0;
        wr.entry        = in_trans;
        unique case (r_state)
            ST_IDLE: begin
                // Hold an end of string only while the last result is unread.
                s_axis_tready  = (in_action != ACT_END) || !r_out_valid || m_axis_tready;
                // Ready is always high for add and symbol while idle.
                scan_cmd.start = s_axis_tvalid && (in_action == ACT_SYMBOL);
                wr.en          = s_axis_tvalid && (in_action == ACT_ADD)
                                 && (r_count < CW'(MAX_TRANSITIONS));
            end
            ST_SCAN: begin
                s_axis_tready = 1'b0;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Config registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_init <= NUM_INIT_W'(1);
            r_acc_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_INITIAL: r_num_init <= i_cfg_wdata[NUM_INIT_W-1:0];
                CFG_ACCEPT_MASK: r_acc_mask <= i_cfg_wdata[MASK_W-1:0];
                default:         r_num_init <= r_num_init;
            endcase
        end
    end

    // Table count, overflow, active set and string tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_active    <= '0;
            r_in_string <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (scan_sts.done) begin
                r_active <= scan_next;
            end
        end else if (in_acc) begin
            unique case (in_action)
                ACT_ADD: begin
                    if (r_count < CW'(MAX_TRANSITIONS)) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                ACT_SYMBOL: begin
                    // Load the start set; the walk reads it once the first entry is read back.
                    r_active    <= start_set;
                    r_in_string <= 1'b1;
                end
                ACT_END: begin
                    r_active    <= '0;
                    r_in_string <= 1'b0;
                end
                default: r_count <= r_count;
            endcase
        end
    end

    // Result register: decouple the result from the command side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && in_action == ACT_END) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_action == ACT_END) begin
            r_out_acc <= |(start_set & mask_set);
            r_out_ovf <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_ovf, r_out_acc};

    nfa_scan #(
        .NUM_STATES      (NUM_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .AW              (AW),
        .CW              (CW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_cmd     (scan_cmd),
        .i_lim     (r_count),
        .i_active  (r_active),
        .o_sts     (scan_sts),
        .o_next    (scan_next)
    );

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> (r_state == ST_SCAN))
        else $error("scan finished outside of a walk");

    a_symbol_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_action == ACT_SYMBOL) |=> (r_state == ST_SCAN && scan_sts.busy))
        else $error("symbol did not start a list walk");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TRANSITIONS))
        else $error("transition count past capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_TRANSITIONS)))
        else $error("overflow flag set with room in the table");

endmodule

FILE: hw/rtl/nfa_scan.sv
// Transition memory and list-walk engine of the NFA string acceptor.
// Depends on nfa_pkg; instantiated by nfa_string_acceptor.
module nfa_scan #(
    parameter int NUM_STATES      = nfa_pkg::NUM_STATES_DEF,
    parameter int MAX_TRANSITIONS = nfa_pkg::MAX_TRANSITIONS_DEF,
    parameter int AW              = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1,
    parameter int CW              = $clog2(MAX_TRANSITIONS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nfa_pkg::t_wr       i_wr,
    input  logic [AW-1:0]      i_wr_addr,
    input  nfa_pkg::t_scan_cmd i_cmd,
    input  logic [CW-1:0]      i_lim,
    input  logic [NUM_STATES-1:0] i_active,
    output nfa_pkg::t_scan_sts o_sts,
    output logic [NUM_STATES-1:0] o_next
);
    import nfa_pkg::*;

    t_trans mem [MAX_TRANSITIONS];

    t_trans                r_rd_data;
    logic                  r_rd_vld;
    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_lim;
    logic [SYMBOL_W-1:0]   r_sym;
    logic [NUM_STATES-1:0] r_next;
    logic [NUM_STATES-1:0] n_next;

    logic                  rd_en;
    logic                  hit;
    logic [63:0]           act_ext;
    logic [NUM_STATES-1:0] to_dec;

    assign rd_en = r_busy && (r_idx < r_lim);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr_addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    // Fold the entry read last cycle into the next-state set.
    always_comb begin
        act_ext = 64'(i_active);
        for (int s = 0; s < NUM_STATES; s++) begin
            to_dec[s] = (7'(r_rd_data.to_state) == 7'(s));
        end
        hit = r_rd_vld
            && (r_rd_data.symbol == r_sym)
            && (7'(r_rd_data.from_state) < 7'(NUM_STATES))
            && (7'(r_rd_data.to_state) < 7'(NUM_STATES))
            && act_ext[{1'b0, r_rd_data.from_state}];
        n_next = r_next | (hit ? to_dec : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.start) begin
            r_busy   <= 1'b1;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else if (r_busy) begin
            r_rd_vld <= rd_en;
            r_done   <= 1'b0;
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (!rd_en && !r_rd_vld) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lim  <= i_lim;
            r_sym  <= i_cmd.symbol;
            r_next <= '0;
        end else if (r_busy && r_rd_vld) begin
            r_next <= n_next;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_next     = r_next;

endmodule
